### src/radar_frame_target_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radar frame target classifier
// Clocked, reset-qualified property macros used by the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef RADAR_FRAME_TARGET_CLASSIFIER_TOP_ASSERT_SVH
`define RADAR_FRAME_TARGET_CLASSIFIER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFTC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rftc_pkg.sv
// ----------------------------------------------------------------------------
// Radar frame target classifier package
// Types, frame delimiters, register indices and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rftc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] len_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_CENTER_ANGLE_LIMIT  = 3'd0;
  localparam cfg_idx_t CFG_BEHIND_MIN_SPEED    = 3'd1;
  localparam cfg_idx_t CFG_BEHIND_MAX_DISTANCE = 3'd2;
  localparam cfg_idx_t CFG_APPROACH_MIN_SPEED  = 3'd3;

  localparam logic [6:0] RST_CENTER_ANGLE_LIMIT  = 7'd5;
  localparam byte_t      RST_BEHIND_MIN_SPEED    = 8'd10;
  localparam byte_t      RST_BEHIND_MAX_DISTANCE = 8'd15;
  localparam byte_t      RST_APPROACH_MIN_SPEED  = 8'd1;

  localparam len_t MAX_LEN = 16'd128;

  localparam byte_t HDR_SEQ [4] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
  localparam byte_t FTR_SEQ [4] = '{8'hF8, 8'hF7, 8'hF6, 8'hF5};

  localparam byte_t ANGLE_OFFSET  = 8'h80;
  localparam byte_t DIR_APPROACH  = 8'h01;

  typedef struct packed {
    logic any_vehicle;
    logic behind_vehicle;
    logic right_vehicle;
    logic left_vehicle;
  } flags_t;

  typedef struct packed {
    flags_t flags;
    byte_t  target_total;
  } result_t;

endpackage

### src/radar_frame_target_classifier_top.sv
// ----------------------------------------------------------------------------
// Radar frame target classifier
// Parses header/length/footer radar frames and classifies targets per byte.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while in_stall is low.
// Every byte is parsed and classified in the cycle it is taken, and the
// result of a frame is registered once the last footer byte is taken.
// Results pass through an output register backed by a one-entry
// skid stage, so in_stall rises only when both hold a result that the
// downstream side has not yet taken.
`timescale 1ns / 1ps

module radar_frame_target_classifier_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  rftc_pkg::cfg_idx_t  cfg_index,
  input  rftc_pkg::cfg_data_t cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_left_vehicle,
  output logic                out_right_vehicle,
  output logic                out_behind_vehicle,
  output logic                out_any_vehicle,
  output logic [7:0]          out_target_total
);

  import rftc_pkg::*;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_FOOT = 2'd3;

  localparam logic [2:0] FP_ANGLE     = 3'd0;
  localparam logic [2:0] FP_DISTANCE  = 3'd1;
  localparam logic [2:0] FP_DIRECTION = 3'd2;
  localparam logic [2:0] FP_SPEED     = 3'd3;
  localparam logic [2:0] FP_LAST      = 3'd4;

  logic [6:0] cal_r;
  byte_t      bms_r;
  byte_t      bmd_r;
  byte_t      ams_r;

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] match_r, match_nxt;
  len_t       flen_r, flen_nxt;
  byte_t      len_lo_r, len_lo_nxt;
  len_t       count_r, count_nxt;
  byte_t      tc_r, tc_nxt;
  logic [2:0] fp_r, fp_nxt;
  byte_t      angle_r, angle_nxt;
  byte_t      dist_r, dist_nxt;
  byte_t      dir_r, dir_nxt;
  logic       stop_r, stop_nxt;
  flags_t     flags_r, flags_nxt;

  logic       out_valid_r, out_valid_nxt;
  result_t    out_r, out_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  result_t    skid_r, skid_nxt;

  logic       in_accept;
  logic       out_pop;
  logic       out_load;
  logic       result_gen;
  result_t    result_data;

  len_t       rx_len;
  logic       len_ok;
  len_t       count_inc;
  logic [10:0] span;
  len_t       span_w;
  logic       live;
  byte_t      mag;
  logic       behind_hit;
  logic       approach_hit;
  logic       angle_pos;
  logic       short_frame;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_pop   = out_valid_r && !out_stall;
  assign out_load  = !out_valid_r || out_pop;

  assign rx_len    = {in_rx_byte, len_lo_r};
  assign len_ok    = (rx_len != '0) && (rx_len < MAX_LEN);
  assign count_inc = count_r + 16'd1;
  assign span      = {1'b0, tc_r, 2'b00} + {3'b000, tc_r} + 11'd2;
  assign span_w    = {5'b00000, span};
  assign live      = (count_r < span_w) && !stop_r;

  assign mag          = angle_r[7] ? {1'b0, angle_r[6:0]} : (ANGLE_OFFSET - angle_r);
  assign angle_pos    = angle_r > ANGLE_OFFSET;
  assign behind_hit   = (mag <= {1'b0, cal_r}) && (in_rx_byte > bms_r) && (dist_r < bmd_r);
  assign approach_hit = (dir_r == DIR_APPROACH) && (in_rx_byte >= ams_r) &&
                        (mag > {1'b0, cal_r});
  assign short_frame  = (tc_r == '0) || (flen_r < span_w);

  always_comb begin
    phase_nxt  = phase_r;
    match_nxt  = match_r;
    flen_nxt   = flen_r;
    len_lo_nxt = len_lo_r;
    count_nxt  = count_r;
    tc_nxt     = tc_r;
    fp_nxt     = fp_r;
    angle_nxt  = angle_r;
    dist_nxt   = dist_r;
    dir_nxt    = dir_r;
    stop_nxt   = stop_r;
    flags_nxt  = flags_r;
    result_gen = 1'b0;
    result_data.flags        = short_frame ? '0 : flags_r;
    result_data.target_total = tc_r;

    if (in_accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == HDR_SEQ[match_r]) begin
            if (match_r == 2'd3) begin
              phase_nxt = PH_LEN;
              match_nxt = '0;
              count_nxt = '0;
            end else begin
              match_nxt = match_r + 2'd1;
            end
          end else begin
            match_nxt = '0;
          end
        end
        PH_LEN: begin
          if (count_r == '0) begin
            len_lo_nxt = in_rx_byte;
            count_nxt  = 16'd1;
          end else begin
            flen_nxt  = rx_len;
            count_nxt = '0;
            match_nxt = '0;
            if (len_ok) begin
              phase_nxt = PH_DATA;
              tc_nxt    = '0;
              fp_nxt    = FP_ANGLE;
              stop_nxt  = 1'b0;
              flags_nxt = '0;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end
        end
        PH_DATA: begin
          if (count_r == '0) begin
            tc_nxt = in_rx_byte;
          end else if (count_r != 16'd1) begin
            if (live) begin
              case (fp_r)
                FP_ANGLE:     angle_nxt = in_rx_byte;
                FP_DISTANCE:  dist_nxt  = in_rx_byte;
                FP_DIRECTION: dir_nxt   = in_rx_byte;
                FP_SPEED: begin
                  if (behind_hit) begin
                    flags_nxt.behind_vehicle = 1'b1;
                    stop_nxt                 = 1'b1;
                  end else if (approach_hit) begin
                    if (angle_pos) begin
                      flags_nxt.right_vehicle = 1'b1;
                    end else begin
                      flags_nxt.left_vehicle = 1'b1;
                    end
                    flags_nxt.any_vehicle = 1'b1;
                  end
                end
                default: ;
              endcase
            end
            fp_nxt = (fp_r >= FP_LAST) ? FP_ANGLE : fp_r + 3'd1;
          end
          count_nxt = count_inc;
          if (count_inc >= flen_r) begin
            phase_nxt = PH_FOOT;
            match_nxt = '0;
          end
        end
        PH_FOOT: begin
          if (in_rx_byte == FTR_SEQ[match_r]) begin
            if (match_r == 2'd3) begin
              phase_nxt  = PH_HUNT;
              match_nxt  = '0;
              result_gen = flen_r >= 16'd2;
            end else begin
              match_nxt = match_r + 2'd1;
            end
          end else begin
            phase_nxt = PH_HUNT;
            match_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          match_nxt = '0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_load) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (result_gen) begin
      if (out_load) begin
        out_valid_nxt = 1'b1;
        out_nxt       = result_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = result_data;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= RST_CENTER_ANGLE_LIMIT;
      bms_r <= RST_BEHIND_MIN_SPEED;
      bmd_r <= RST_BEHIND_MAX_DISTANCE;
      ams_r <= RST_APPROACH_MIN_SPEED;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CENTER_ANGLE_LIMIT:  cal_r <= cfg_wdata[6:0];
        CFG_BEHIND_MIN_SPEED:    bms_r <= cfg_wdata;
        CFG_BEHIND_MAX_DISTANCE: bmd_r <= cfg_wdata;
        CFG_APPROACH_MIN_SPEED:  ams_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      match_r      <= '0;
      flen_r       <= '0;
      len_lo_r     <= '0;
      count_r      <= '0;
      tc_r         <= '0;
      fp_r         <= FP_ANGLE;
      stop_r       <= 1'b0;
      flags_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      match_r      <= match_nxt;
      flen_r       <= flen_nxt;
      len_lo_r     <= len_lo_nxt;
      count_r      <= count_nxt;
      tc_r         <= tc_nxt;
      fp_r         <= fp_nxt;
      stop_r       <= stop_nxt;
      flags_r      <= flags_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
    dist_r  <= dist_nxt;
    dir_r   <= dir_nxt;
    out_r   <= out_nxt;
    skid_r  <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_left_vehicle   = out_r.flags.left_vehicle;
  assign out_right_vehicle  = out_r.flags.right_vehicle;
  assign out_behind_vehicle = out_r.flags.behind_vehicle;
  assign out_any_vehicle    = out_r.flags.any_vehicle;
  assign out_target_total   = out_r.target_total;

`include "radar_frame_target_classifier_top_assert.svh"

  `RFTC_ASSERT_SAME(a_skid_implies_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `RFTC_ASSERT_SAME(a_data_len_legal, phase_r == PH_DATA, (flen_r != '0) && (flen_r < MAX_LEN), "data phase with illegal length")
  `RFTC_ASSERT_SAME(a_data_count_bound, phase_r == PH_DATA, count_r < flen_r, "data count beyond frame length")
  `RFTC_ASSERT_NEXT(a_result_lands, result_gen && !skid_valid_r, out_valid_r, "frame result not registered")

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Radar frame target classifier testbench
// Streams radar byte frames into the classifier while both sides of the data
// path idle at random. A predictor inside the bench follows the frame parser
// and the target rules byte by byte and queues the report expected for each
// complete frame. Every report that leaves the block is compared, field by
// field, with the oldest expected one. The run covers several register
// settings, a long downstream hold-off, and drained pauses between stimulus
// batches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rftc_pkg::*;

  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam cfg_idx_t    SPARE_REG_INDEX  = CFG_APPROACH_MIN_SPEED + 1'b1;

  typedef enum logic [1:0] {
    SEEK_HEADER,
    READ_LENGTH,
    READ_PAYLOAD,
    CHECK_FOOTER
  } parse_phase_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  byte_t     in_rx_byte = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  logic      out_left_vehicle;
  logic      out_right_vehicle;
  logic      out_behind_vehicle;
  logic      out_any_vehicle;
  byte_t     out_target_total;

  byte_t       pending_bytes[$];
  result_t     expected_reports[$];
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 87;
  int unsigned hold_requests = 0;
  int unsigned holds_granted = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Predictor state and its copy of the registers.
  parse_phase_e parse_phase = SEEK_HEADER;
  logic [2:0]   match_pos = '0;
  logic         len_high_next = 1'b0;
  len_t         frame_len = '0;
  byte_t        len_low = '0;
  len_t         payload_idx = '0;
  byte_t        tgt_count = '0;
  logic [2:0]   field_pos = '0;
  byte_t        held_angle = '0;
  byte_t        held_dist = '0;
  byte_t        held_dir = '0;
  logic         scan_done = 1'b0;
  flags_t       frame_flags = '0;
  logic [6:0]   angle_limit = RST_CENTER_ANGLE_LIMIT;
  byte_t        behind_speed = RST_BEHIND_MIN_SPEED;
  byte_t        behind_dist = RST_BEHIND_MAX_DISTANCE;
  byte_t        approach_speed = RST_APPROACH_MIN_SPEED;

  radar_frame_target_classifier_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_vehicle   (out_left_vehicle),
    .out_right_vehicle  (out_right_vehicle),
    .out_behind_vehicle (out_behind_vehicle),
    .out_any_vehicle    (out_any_vehicle),
    .out_target_total   (out_target_total)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic predict_rx_byte(input byte_t b);
    int          angle;
    int unsigned mag;
    result_t     rep;
    case (parse_phase)
      SEEK_HEADER: begin
        if (b == HDR_SEQ[match_pos[1:0]]) begin
          match_pos = match_pos + 1'b1;
          if (match_pos >= 3'd4) begin
            parse_phase = READ_LENGTH;
            match_pos = '0;
            len_high_next = 1'b0;
          end
        end else begin
          match_pos = '0;
        end
      end
      READ_LENGTH: begin
        if (!len_high_next) begin
          len_low = b;
          len_high_next = 1'b1;
        end else begin
          frame_len = {b, len_low};
          len_high_next = 1'b0;
          match_pos = '0;
          if (frame_len != '0 && frame_len < MAX_LEN) begin
            parse_phase = READ_PAYLOAD;
            payload_idx = '0;
            tgt_count = '0;
            field_pos = '0;
            scan_done = 1'b0;
            frame_flags = '0;
          end else begin
            parse_phase = SEEK_HEADER;
          end
        end
      end
      READ_PAYLOAD: begin
        if (payload_idx == '0) begin
          tgt_count = b;
        end else if (payload_idx >= 16'd2) begin
          if (int'(payload_idx) < 2 + 5 * int'(tgt_count) && !scan_done) begin
            case (field_pos)
              3'd0: held_angle = b;
              3'd1: held_dist = b;
              3'd2: held_dir = b;
              3'd3: begin
                angle = int'(held_angle) - int'(ANGLE_OFFSET);
                mag = (angle < 0) ? -angle : angle;
                if (mag <= int'(angle_limit) && b > behind_speed && held_dist < behind_dist) begin
                  frame_flags.behind_vehicle = 1'b1;
                  scan_done = 1'b1;
                end else if (held_dir == DIR_APPROACH && b >= approach_speed &&
                             mag > int'(angle_limit)) begin
                  if (angle > 0) frame_flags.right_vehicle = 1'b1;
                  else frame_flags.left_vehicle = 1'b1;
                  frame_flags.any_vehicle = 1'b1;
                end
              end
              default: ;
            endcase
          end
          field_pos = (field_pos >= 3'd4) ? 3'd0 : field_pos + 1'b1;
        end
        payload_idx = payload_idx + 1'b1;
        if (payload_idx >= frame_len) begin
          parse_phase = CHECK_FOOTER;
          match_pos = '0;
        end
      end
      default: begin
        if (b == FTR_SEQ[match_pos[1:0]]) begin
          match_pos = match_pos + 1'b1;
          if (match_pos >= 3'd4) begin
            parse_phase = SEEK_HEADER;
            match_pos = '0;
            if (frame_len >= 16'd2) begin
              rep.flags = frame_flags;
              if (tgt_count == '0 || int'(frame_len) < 2 + 5 * int'(tgt_count))
                rep.flags = '0;
              rep.target_total = tgt_count;
              expected_reports.push_back(rep);
            end
          end
        end else begin
          parse_phase = SEEK_HEADER;
          match_pos = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && cfg_wr_en) begin
      case (cfg_index)
        CFG_CENTER_ANGLE_LIMIT:  angle_limit <= cfg_wdata[6:0];
        CFG_BEHIND_MIN_SPEED:    behind_speed <= cfg_wdata;
        CFG_BEHIND_MAX_DISTANCE: behind_dist <= cfg_wdata;
        CFG_APPROACH_MIN_SPEED:  approach_speed <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : driver
    if (rst_n) begin
      if (in_valid && !in_stall) predict_rx_byte(in_rx_byte);
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_granted != hold_requests) begin
      holds_granted <= holds_granted + 1;
      hold_left <= LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("report with none expected: target_total %0d", out_target_total);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("left_vehicle", 8'(want.flags.left_vehicle), 8'(out_left_vehicle));
        check_field("right_vehicle", 8'(want.flags.right_vehicle), 8'(out_right_vehicle));
        check_field("behind_vehicle", 8'(want.flags.behind_vehicle),
                    8'(out_behind_vehicle));
        check_field("any_vehicle", 8'(want.flags.any_vehicle), 8'(out_any_vehicle));
        check_field("target_total", want.target_total, out_target_total);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic byte_t noise_byte();
    if ($urandom_range(0, 1)) return byte_t'($urandom);
    return byte_t'(8'hF1 + $urandom_range(0, 7));
  endfunction

  task automatic push_header();
    for (int i = 0; i < 4; i++) pending_bytes.push_back(HDR_SEQ[i]);
  endtask

  task automatic push_length(input len_t length);
    pending_bytes.push_back(length[7:0]);
    pending_bytes.push_back(length[15:8]);
  endtask

  task automatic push_footer(input bit intact);
    int unsigned k;
    k = intact ? 4 : $urandom_range(0, 3);
    for (int i = 0; i < k; i++) pending_bytes.push_back(FTR_SEQ[i]);
    if (!intact) pending_bytes.push_back(FTR_SEQ[k] ^ (8'h01 << $urandom_range(0, 7)));
  endtask

  // Target bytes are biased towards the current thresholds.
  function automatic byte_t target_field(input int unsigned slot);
    int unsigned off;
    byte_t       v;
    v = byte_t'($urandom);
    case (slot)
      0: if ($urandom_range(0, 1)) begin
        off = $urandom_range(0, int'(angle_limit) + 3);
        if ($urandom_range(0, 1))
          v = (int'(ANGLE_OFFSET) + off > 255) ? 8'hFF : byte_t'(int'(ANGLE_OFFSET) + off);
        else
          v = (off > int'(ANGLE_OFFSET)) ? 8'h00 : byte_t'(int'(ANGLE_OFFSET) - off);
      end
      1: if ($urandom_range(0, 1)) v = behind_dist - byte_t'($urandom_range(0, 1));
      2: if ($urandom_range(0, 9) < 6) v = DIR_APPROACH;
      3: case ($urandom_range(0, 3))
        0: v = behind_speed + byte_t'($urandom_range(0, 1));
        1: v = approach_speed - byte_t'($urandom_range(0, 1));
        default: ;
      endcase
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_random_frame();
    int unsigned pick;
    int unsigned count;
    int unsigned length;
    len_t        bad_len;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) pending_bytes.push_back(noise_byte());
    end else if (pick < 13) begin
      push_header();
      case ($urandom_range(0, 3))
        0: bad_len = '0;
        1: bad_len = MAX_LEN;
        2: bad_len = '1;
        default: bad_len = len_t'($urandom_range(int'(MAX_LEN), 65535));
      endcase
      push_length(bad_len);
    end else if (pick < 18) begin
      push_header();
      push_length(16'd1);
      pending_bytes.push_back(byte_t'($urandom));
      push_footer($urandom_range(0, 4) != 0);
    end else begin
      count = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
      length = 2 + 5 * count;
      case ($urandom_range(0, 9))
        0: length = $urandom_range(2, length);
        1: length = length + $urandom_range(1, 9);
        default: ;
      endcase
      if (length >= int'(MAX_LEN)) length = $urandom_range(2, int'(MAX_LEN) - 1);
      push_header();
      push_length(len_t'(length));
      pending_bytes.push_back(byte_t'(count));
      pending_bytes.push_back(byte_t'($urandom));
      for (int i = 2; i < length; i++) pending_bytes.push_back(target_field((i - 2) % 5));
      push_footer($urandom_range(0, 9) != 0);
    end
  endtask

  task automatic wait_for_quiet();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [6:0] limit_val, input byte_t bspeed_val,
                                input byte_t bdist_val, input byte_t aspeed_val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_CENTER_ANGLE_LIMIT;
    cfg_wdata <= {1'b0, limit_val};
    @(posedge clk);
    cfg_index <= CFG_BEHIND_MIN_SPEED;
    cfg_wdata <= bspeed_val;
    @(posedge clk);
    cfg_index <= CFG_BEHIND_MAX_DISTANCE;
    cfg_wdata <= bdist_val;
    @(posedge clk);
    cfg_index <= CFG_APPROACH_MIN_SPEED;
    cfg_wdata <= aspeed_val;
    @(posedge clk);
    cfg_index <= cfg_idx_t'($urandom_range(int'(SPARE_REG_INDEX), 2 ** CFG_IDX_W - 1));
    cfg_wdata <= cfg_data_t'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Each batch drains completely before the next is queued, so the sender
  // pauses until every expected report has arrived.
  task automatic run_random_phase(input int unsigned byte_budget, input bit with_hold);
    for (int batch = 0; batch < 3; batch++) begin
      if (with_hold && batch == 0) hold_requests++;
      while (pending_bytes.size() < byte_budget / 3) queue_random_frame();
      wait_for_quiet();
    end
  endtask

  task automatic queue_directed_frames();
    byte_t body [17] = '{8'd2, 8'hFF,
                         8'h00, 8'hFF, DIR_APPROACH, 8'hFF, 8'h00,
                         ANGLE_OFFSET, 8'h00, 8'h00, 8'd11, 8'hFF,
                         8'hFF, 8'h00, DIR_APPROACH, 8'hFF, 8'h55};
    // A broken header start that must not be taken up again.
    pending_bytes.push_back(HDR_SEQ[0]);
    pending_bytes.push_back(HDR_SEQ[1]);
    pending_bytes.push_back(HDR_SEQ[0]);
    push_header();
    push_length(16'd17);
    foreach (body[i]) pending_bytes.push_back(body[i]);
    push_footer(1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    queue_directed_frames();
    wait_for_quiet();

    apply_settings(7'd20, 8'd40, 8'd60, 8'd3);
    run_random_phase(180, 1'b1);

    send_idle_pct = 87;
    recv_idle_pct = 33;
    apply_settings(7'd127, 8'd255, 8'd255, 8'd255);
    run_random_phase(180, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(7'd0, 8'd0, 8'd0, 8'd0);
    run_random_phase(180, 1'b1);

    apply_settings(RST_CENTER_ANGLE_LIMIT, RST_BEHIND_MIN_SPEED,
                   RST_BEHIND_MAX_DISTANCE, RST_APPROACH_MIN_SPEED);
    run_random_phase(180, 1'b0);

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
